// ----- hw/rtl/shte_pkg.sv -----
// Shared types and constants for the SWD host transfer engine.
`default_nettype none

package shte_pkg;

    // Input item: one tick or one transfer start.
    typedef struct packed {
        logic        cmd;
        logic [3:0]  request;
        logic [31:0] write_data;
        logic [7:0]  idle_count;
        logic        line_in;
    } t_in_item;

    // Result item: one SWCLK period.
    typedef struct packed {
        logic        line_out;
        logic        line_drive_enable;
        logic        busy_res;
        logic        done_res;
        logic [2:0]  ack_bits;
        logic        parity_error;
        logic [31:0] read_data;
    } t_out_item;

    // Configuration registers.
    typedef struct packed {
        logic [2:0] turnaround;
        logic       dummy_data;
    } t_cfg;

    localparam logic CFG_TURNAROUND = 1'b0;
    localparam logic CFG_DUMMY_DATA = 1'b1;

    localparam logic [2:0] CFG_TURNAROUND_RST = 3'd1;

    localparam logic [2:0] ACK_OK    = 3'b001;
    localparam logic [2:0] ACK_WAIT  = 3'b010;
    localparam logic [2:0] ACK_FAULT = 3'b100;

    localparam logic [5:0] LEN_HDR     = 6'd8;
    localparam logic [5:0] LEN_ACK     = 6'd3;
    localparam logic [5:0] LEN_DATA    = 6'd32;
    localparam logic [5:0] LEN_PAR     = 6'd1;
    localparam logic [5:0] LEN_BACKOFF = 6'd33;

    typedef enum logic [11:0] {
        PH_IDLE    = 12'h001,
        PH_HDR     = 12'h002,
        PH_TURN1   = 12'h004,
        PH_ACK     = 12'h008,
        PH_RDATA   = 12'h010,
        PH_RPAR    = 12'h020,
        PH_TURN2R  = 12'h040,
        PH_TURN2W  = 12'h080,
        PH_WDATA   = 12'h100,
        PH_WPAR    = 12'h200,
        PH_IDLEC   = 12'h400,
        PH_BACKOFF = 12'h800
    } t_phase;

endpackage

`default_nettype wire

// ----- hw/rtl/shte_ifs.sv -----
// Valid/ready channel interfaces for input and result items.
`default_nettype none

interface shte_in_if
    import shte_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface shte_out_if
    import shte_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/swd_host_transfer_engine_top.sv -----
// Top level of the SWD host transfer engine: input stage, sequencer, result register.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+------------------------------------------------
//  i_in    | in  | valid / ready    | cmd, request, write_data, idle_count, line_in
//  o_out   | out | valid / ready    | line_out, drive enable, busy, done, ack, perr, rdata
//  cfg     | in  | i_cfg_we         | i_cfg_idx (0 turnaround, 1 dummy data), i_cfg_wdata
//
// Each item is registered in the input stage, then takes one step through the sequencer
// into the result register; one item per cycle sustained while o_out.ready stays high.
// Every cmd=0 tick yields one result; a start item yields none.
// Synchronous active-low reset idles the sequencer; turnaround resets to 1, dummy to 0.
// A stalled result holds the result register; the input stage then holds its item and
// ready drops only while both are full.
`default_nettype none

module swd_host_transfer_engine_top
    import shte_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    shte_in_if.sink         i_in,
    shte_out_if.source      o_out,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [2:0] i_cfg_wdata
);

    t_cfg      r_cfg;
    logic      r_s_vld;
    t_in_item  r_s_item;
    logic      r_o_vld;
    t_out_item r_o_item;

    logic      adv;
    t_out_item res;
    logic      res_vld;

    // Stage item moves on when the result register is free or draining.
    assign adv         = r_s_vld && (!r_o_vld || o_out.ready);
    assign i_in.ready  = !r_s_vld || adv;
    assign o_out.valid = r_o_vld;
    assign o_out.data  = r_o_item;

    // Configuration registers; the user writes them only while idle, the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.turnaround <= CFG_TURNAROUND_RST;
            r_cfg.dummy_data <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TURNAROUND: r_cfg.turnaround <= i_cfg_wdata;
                CFG_DUMMY_DATA: r_cfg.dummy_data <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_s_vld <= 1'b1;
        end else if (adv) begin
            r_s_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s_item <= i_in.data;
        end
    end

    shte_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (adv),
        .i_item    (r_s_item),
        .i_cfg     (r_cfg),
        .o_res     (res),
        .o_res_vld (res_vld)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (adv && res_vld) begin
            r_o_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res_vld) begin
            r_o_item <= res;
        end
    end

    a_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_vld && !adv) |=> (r_s_vld && $stable(r_s_item)))
        else $error("input stage item lost while stalled");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !o_out.ready) |=> r_o_vld)
        else $error("result dropped while stalled");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && res_vld) |-> (!r_o_vld || o_out.ready))
        else $error("result register overwritten");

endmodule

`default_nettype wire

// ----- hw/rtl/shte_core.sv -----
// SWD sequencer: phase state, bit counter, shift word and per-tick step logic.
`default_nettype none

module shte_core
    import shte_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_in_item  i_item,
    input  wire t_cfg      i_cfg,
    output t_out_item      o_res,
    output logic           o_res_vld
);

    typedef struct packed {
        t_phase     ph;
        logic [5:0] bc;
    } t_entry;

    t_phase      r_phase, n_phase;
    logic [5:0]  r_bc, n_bc;
    logic [31:0] r_shift, n_shift;
    logic [3:0]  r_req, n_req;
    logic [7:0]  r_idle, n_idle;
    logic [2:0]  r_ack, n_ack;
    logic        r_par, n_par;

    logic        rd;
    logic        last;
    logic [7:0]  hdr;
    logic [2:0]  hdr_idx;
    logic [1:0]  ack_idx;
    t_entry      ent;

    function automatic t_phase f_after(t_phase ph, logic [2:0] ack, logic is_rd);
        t_phase nx;
        begin
            unique case (ph)
                PH_HDR:    nx = PH_TURN1;
                PH_TURN1:  nx = PH_ACK;
                PH_ACK:    nx = (ack == ACK_OK) ? (is_rd ? PH_RDATA : PH_TURN2W) : PH_BACKOFF;
                PH_RDATA:  nx = PH_RPAR;
                PH_RPAR:   nx = PH_TURN2R;
                PH_TURN2R: nx = PH_IDLEC;
                PH_TURN2W: nx = PH_WDATA;
                PH_WDATA:  nx = PH_WPAR;
                PH_WPAR:   nx = PH_IDLEC;
                default:   nx = PH_IDLE;
            endcase
            return nx;
        end
    endfunction

    function automatic logic [5:0] f_len(t_phase ph, t_cfg cfg, logic [7:0] idl,
                                         logic [2:0] ack);
        logic [5:0] len;
        begin
            unique case (ph)
                PH_HDR:             len = LEN_HDR;
                PH_ACK:             len = LEN_ACK;
                PH_RDATA, PH_WDATA: len = LEN_DATA;
                PH_RPAR, PH_WPAR:   len = LEN_PAR;
                PH_IDLEC:           len = {5'd0, |idl};
                PH_BACKOFF: begin
                    if ((ack == ACK_WAIT || ack == ACK_FAULT) && !cfg.dummy_data)
                        len = {3'd0, cfg.turnaround};
                    else
                        len = LEN_BACKOFF + {3'd0, cfg.turnaround};
                end
                PH_IDLE:            len = '0;
                default:            len = {3'd0, cfg.turnaround};
            endcase
            return len;
        end
    endfunction

    // Enter a phase, skipping zero-length ones; at most two skips in a row.
    function automatic t_entry f_enter(t_phase ph, t_cfg cfg, logic [7:0] idl,
                                       logic [2:0] ack, logic is_rd);
        t_entry     e;
        t_phase     p;
        logic       stop;
        logic [5:0] len;
        begin
            p    = ph;
            stop = 1'b0;
            e.ph = PH_IDLE;
            e.bc = '0;
            for (int k = 0; k < 3; k++) begin
                len = f_len(p, cfg, idl, ack);
                if (!stop) begin
                    if (p == PH_IDLE) begin
                        stop = 1'b1;
                        e.ph = PH_IDLE;
                        e.bc = '0;
                    end else if (len != 6'd0) begin
                        stop = 1'b1;
                        e.ph = p;
                        e.bc = (p == PH_IDLEC) ? 6'd0 : len;
                    end else begin
                        p = f_after(p, ack, is_rd);
                    end
                end
            end
            return e;
        end
    endfunction

    assign rd      = r_req[1];
    assign hdr     = {1'b1, 1'b0, ^r_req, r_req, 1'b1};
    assign hdr_idx = 3'(3'd0 - r_bc[2:0]);
    assign ack_idx = 2'(2'd3 - r_bc[1:0]);

    always_comb begin
        n_phase   = r_phase;
        n_bc      = r_bc;
        n_shift   = r_shift;
        n_req     = r_req;
        n_idle    = r_idle;
        n_ack     = r_ack;
        n_par     = r_par;
        last      = 1'b0;
        ent       = '{ph: PH_IDLE, bc: '0};
        o_res     = '0;
        o_res_vld = 1'b0;

        if (i_item.cmd) begin
            // start only from idle; otherwise dropped
            if (r_phase == PH_IDLE) begin
                n_req   = i_item.request;
                n_shift = i_item.write_data;
                n_idle  = i_item.idle_count;
                n_ack   = '0;
                n_par   = ^i_item.write_data;
                n_phase = PH_HDR;
                n_bc    = LEN_HDR;
            end
        end else begin
            o_res_vld = 1'b1;
            if (r_phase == PH_IDLE) begin
                o_res.line_out          = 1'b1;
                o_res.line_drive_enable = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_HDR: begin
                        o_res.line_drive_enable = 1'b1;
                        o_res.line_out          = hdr[hdr_idx];
                    end
                    PH_ACK:   n_ack = r_ack | (3'(i_item.line_in) << ack_idx);
                    PH_RDATA: n_shift = {i_item.line_in, r_shift[31:1]};
                    PH_RPAR:  n_par = (^r_shift) ^ i_item.line_in;
                    PH_WDATA: begin
                        o_res.line_drive_enable = 1'b1;
                        o_res.line_out          = r_shift[0];
                        n_shift                 = {1'b0, r_shift[31:1]};
                    end
                    PH_WPAR: begin
                        o_res.line_drive_enable = 1'b1;
                        o_res.line_out          = r_par;
                    end
                    PH_IDLEC: o_res.line_drive_enable = 1'b1;
                    default: ;
                endcase

                if (r_phase == PH_IDLEC) begin
                    n_idle = r_idle - 8'd1;
                    last   = (n_idle == 8'd0);
                end else begin
                    n_bc = r_bc - 6'd1;
                    last = (n_bc == 6'd0);
                end

                if (last) begin
                    ent     = f_enter(f_after(r_phase, n_ack, rd), i_cfg, n_idle, n_ack, rd);
                    n_phase = ent.ph;
                    n_bc    = ent.bc;
                end

                o_res.busy_res = 1'b1;
                if (n_phase == PH_IDLE) begin
                    o_res.done_res = 1'b1;
                    o_res.ack_bits = n_ack;
                    if (n_ack == ACK_OK && rd) begin
                        o_res.parity_error = n_par;
                        o_res.read_data    = n_shift;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bc    <= '0;
            r_shift <= '0;
            r_req   <= '0;
            r_idle  <= '0;
            r_ack   <= '0;
            r_par   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_bc    <= n_bc;
            r_shift <= n_shift;
            r_req   <= n_req;
            r_idle  <= n_idle;
            r_ack   <= n_ack;
            r_par   <= n_par;
        end
    end

    a_start_enters_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.cmd && r_phase == PH_IDLE) |=> (r_phase == PH_HDR && r_bc == LEN_HDR))
        else $error("start from idle did not load header phase");

    a_busy_start_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.cmd && r_phase != PH_IDLE) |=> ($stable(r_phase) && $stable(r_req)))
        else $error("start while busy changed transfer state");

    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HDR) |-> (r_bc >= 6'd1 && r_bc <= LEN_HDR))
        else $error("header bit counter out of range");

endmodule

`default_nettype wire
